>>> design/ihex_pkg.sv
package ihex_pkg;

    localparam int MAX_DATA_BYTES = 16;
    localparam int POS_CAP        = 2 * MAX_DATA_BYTES + 11;
    localparam int POS_W          = $clog2(POS_CAP + 1);
    localparam int IDX_W          = $clog2(MAX_DATA_BYTES);
    localparam int CNT_W          = IDX_W + 1;
    localparam int BYTE_IDX_W     = $clog2(POS_CAP / 2 + 1);
    localparam int ADDR_W         = 24;

    localparam logic [7:0] LINE_END    = 8'h0A;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_NAK    = 2'd2;

    localparam logic [7:0] REC_DATA    = 8'h00;
    localparam logic [7:0] REC_EOF     = 8'h01;
    localparam logic [7:0] REC_EXTADDR = 8'h04;

    localparam logic CFG_APP_START  = 1'b0;
    localparam logic CFG_HIGH_LIMIT = 1'b1;

    localparam logic [ADDR_W-1:0] APP_START_RESET  = 24'd1024;
    localparam logic [7:0]        HIGH_LIMIT_RESET = 8'd48;

    // hex digit value, wraps modulo 256 for characters outside the digit set
    function automatic logic [7:0] nibble_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHAR_A) begin
            v = c - CHAR_A + 8'd10;
        end else begin
            v = c - CHAR_ZERO;
        end
        return v;
    endfunction

endpackage

>>> design/ihex_char_if.sv
interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_char;

    modport source (output valid, output rx_char, input ready);
    modport sink   (input valid, input rx_char, output ready);
endinterface

>>> design/ihex_res_if.sv
interface ihex_res_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [ihex_pkg::ADDR_W-1:0]  write_address;
    logic [7:0]                   write_data;
    logic                         end_of_file;
    logic                         last;

    modport source (output valid, output kind, output write_address, output write_data,
                    output end_of_file, output last, input ready);
    modport sink   (input valid, input kind, input write_address, input write_data,
                    input end_of_file, input last, output ready);
endinterface

>>> design/intel_hex_record_loader.sv
// channel   dir   payload                                          request
// i_rx      in    rx_char[7:0]                                     one line character
// o_res     out   kind, write_address, write_data, end_of_file,   one write, ack or nak
//                 last
//
// sequence: a character is accepted, then passes once through the shared 24-bit
// adder; a line end is closed by an ack or nak, and for a written data record first
// goes through an address compare and a write burst, each result stalled while o_res is full
// reset: i_rst_n synchronous active low, clears sequencer, line state and result valid flag
// stalls: o_res has its own result register; a held result stalls the write burst and the closing ack or nak

module intel_hex_record_loader (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [ihex_pkg::ADDR_W-1:0] i_cfg_data,
    ihex_char_if.sink                   i_rx,
    ihex_res_if.source                  o_res
);

    // sequencer codes
    localparam logic [2:0] S_IDLE  = 3'd0;   // waiting for a character
    localparam logic [2:0] S_CHAR  = 3'd1;   // decode character or close line
    localparam logic [2:0] S_CMP   = 3'd2;   // address against application start
    localparam logic [2:0] S_WRITE = 3'd3;   // write burst, one byte a cycle while o_res is free
    localparam logic [2:0] S_FIN   = 3'd4;   // closing ack or nak

    // configuration
    logic [ihex_pkg::ADDR_W-1:0] r_app_start;
    logic [7:0]                  r_high_limit;

    // sequencer and line state
    logic [2:0]                  r_state, n_state;
    logic [7:0]                  r_char;
    logic [ihex_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [7:0]                  r_first, n_first;
    logic [7:0]                  r_cks, n_cks;
    logic [7:0]                  r_len, n_len;
    logic [15:0]                 r_addr_low, n_addr_low;
    logic [7:0]                  r_type, n_type;
    logic [7:0]                  r_addr_high, n_addr_high;
    logic                        r_overflow, n_overflow;
    logic                        r_finished, n_finished;
    logic [ihex_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic [1:0]                  r_fin_kind, n_fin_kind;
    logic                        r_fin_eof, n_fin_eof;

    // data bytes of the current line
    logic [7:0] r_buf [ihex_pkg::MAX_DATA_BYTES];
    logic                        buf_we;
    logic [ihex_pkg::IDX_W-1:0]  buf_waddr;

    // result register
    logic                        r_out_valid, n_out_valid;
    logic [1:0]                  r_out_kind, n_out_kind;
    logic [ihex_pkg::ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [7:0]                  r_out_data, n_out_data;
    logic                        r_out_eof, n_out_eof;
    logic                        r_out_last, n_out_last;
    logic                        out_free;

    // shared adder: checksum sums, address compare and write addresses
    logic [ihex_pkg::ADDR_W-1:0] alu_a, alu_b;
    logic                        alu_cin;
    logic [ihex_pkg::ADDR_W:0]   alu_sum;

    // character decode
    logic [7:0]                       nib;
    logic [7:0]                       byte_val;
    logic [ihex_pkg::BYTE_IDX_W-1:0]  byte_idx;
    logic [ihex_pkg::BYTE_IDX_W-1:0]  data_idx;
    logic                             line_done;
    logic [9:0]                       need_pos;
    logic [ihex_pkg::ADDR_W-1:0]      full_addr;

    assign i_rx.ready = (r_state == S_IDLE);

    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_out_kind;
    assign o_res.write_address = r_out_addr;
    assign o_res.write_data    = r_out_data;
    assign o_res.end_of_file   = r_out_eof;
    assign o_res.last          = r_out_last;

    assign out_free = !r_out_valid || o_res.ready;

    assign nib       = ihex_pkg::nibble_value(r_char);
    assign byte_val  = {r_first[3:0], 4'b0000} | nib;
    assign byte_idx  = ihex_pkg::BYTE_IDX_W'(r_pos >> 1) - ihex_pkg::BYTE_IDX_W'(1);
    assign data_idx  = byte_idx - ihex_pkg::BYTE_IDX_W'(4);
    assign need_pos  = {1'b0, r_len, 1'b0} + 10'd11;
    assign line_done = ({{(10 - ihex_pkg::POS_W){1'b0}}, r_pos} >= need_pos);
    assign full_addr = {r_addr_high, r_addr_low};

    // operand selection for the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_cin = 1'b0;
        unique case (r_state)
            S_CHAR: begin
                alu_a = {16'b0, r_cks};
                alu_b = {16'b0, byte_val};
            end
            S_CMP: begin
                // addr - start, carry out set when addr >= start
                alu_a   = full_addr;
                alu_b   = ~r_app_start;
                alu_cin = 1'b1;
            end
            S_WRITE: begin
                alu_a = full_addr;
                alu_b = {{(ihex_pkg::ADDR_W - ihex_pkg::CNT_W){1'b0}}, r_idx};
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b}
                   + {{ihex_pkg::ADDR_W{1'b0}}, alu_cin};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_first     = r_first;
        n_cks       = r_cks;
        n_len       = r_len;
        n_addr_low  = r_addr_low;
        n_type      = r_type;
        n_addr_high = r_addr_high;
        n_overflow  = r_overflow;
        n_finished  = r_finished;
        n_idx       = r_idx;
        n_fin_kind  = r_fin_kind;
        n_fin_eof   = r_fin_eof;
        buf_we      = 1'b0;
        buf_waddr   = data_idx[ihex_pkg::IDX_W-1:0];

        n_out_valid = r_out_valid && !o_res.ready;
        n_out_kind  = r_out_kind;
        n_out_addr  = r_out_addr;
        n_out_data  = r_out_data;
        n_out_eof   = r_out_eof;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                // after end of file every character is dropped here
                if (i_rx.valid && !r_finished) begin
                    n_state = S_CHAR;
                end
            end

            S_CHAR: begin
                n_state = S_IDLE;
                if (r_char == ihex_pkg::LINE_END) begin
                    n_state    = S_FIN;
                    n_fin_kind = ihex_pkg::KIND_ACK;
                    n_fin_eof  = 1'b0;
                    if (!line_done || r_overflow || r_cks != 8'd0) begin
                        n_fin_kind = ihex_pkg::KIND_NAK;
                    end else if (r_type == ihex_pkg::REC_DATA) begin
                        n_state = S_CMP;
                    end else if (r_type == ihex_pkg::REC_EOF) begin
                        n_finished = 1'b1;
                        n_fin_eof  = 1'b1;
                    end else if (r_type == ihex_pkg::REC_EXTADDR && r_len >= 8'd2) begin
                        n_addr_high = r_buf[1];
                    end
                end else if (r_pos < ihex_pkg::POS_W'(ihex_pkg::POS_CAP)) begin
                    n_pos = r_pos + ihex_pkg::POS_W'(1);
                    if (r_pos != '0) begin
                        if (r_pos[0]) begin
                            n_first = nib;
                        end else begin
                            // bytes past the checksum byte leave the sum alone
                            if (byte_idx < ihex_pkg::BYTE_IDX_W'(4)
                                || {{(8 - ihex_pkg::BYTE_IDX_W){1'b0}}, data_idx} <= r_len) begin
                                n_cks = alu_sum[7:0];
                            end
                            case (byte_idx)
                                ihex_pkg::BYTE_IDX_W'(0): n_len  = byte_val;
                                ihex_pkg::BYTE_IDX_W'(1): n_addr_low = {byte_val, r_addr_low[7:0]};
                                ihex_pkg::BYTE_IDX_W'(2): n_addr_low = {r_addr_low[15:8], byte_val};
                                ihex_pkg::BYTE_IDX_W'(3): n_type = byte_val;
                                default: begin
                                    if ({{(8 - ihex_pkg::BYTE_IDX_W){1'b0}}, data_idx} < r_len) begin
                                        if (data_idx < ihex_pkg::BYTE_IDX_W'(ihex_pkg::MAX_DATA_BYTES))
                                        begin
                                            buf_we = 1'b1;
                                        end else begin
                                            n_overflow = 1'b1;
                                        end
                                    end
                                end
                            endcase
                        end
                    end
                end
            end

            S_CMP: begin
                n_idx = '0;
                if (r_addr_high < r_high_limit && alu_sum[ihex_pkg::ADDR_W]) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_WRITE: begin
                // a complete line holds at most MAX_DATA_BYTES data bytes
                if ({{(8 - ihex_pkg::CNT_W){1'b0}}, r_idx} == r_len) begin
                    n_state = S_FIN;
                end else if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = ihex_pkg::KIND_WRITE;
                    n_out_addr  = alu_sum[ihex_pkg::ADDR_W-1:0];
                    n_out_data  = r_buf[r_idx[ihex_pkg::IDX_W-1:0]];
                    n_out_eof   = 1'b0;
                    n_out_last  = 1'b0;
                    n_idx       = r_idx + ihex_pkg::CNT_W'(1);
                end
            end

            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_fin_kind;
                    n_out_addr  = '0;
                    n_out_data  = '0;
                    n_out_eof   = r_fin_eof;
                    n_out_last  = 1'b1;
                    // clear per-line state
                    n_pos      = '0;
                    n_first    = '0;
                    n_cks      = '0;
                    n_len      = '0;
                    n_addr_low = '0;
                    n_type     = '0;
                    n_overflow = 1'b0;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_first      <= '0;
            r_cks        <= '0;
            r_len        <= '0;
            r_addr_low   <= '0;
            r_type       <= '0;
            r_addr_high  <= '0;
            r_overflow   <= 1'b0;
            r_finished   <= 1'b0;
            r_idx        <= '0;
            r_fin_kind   <= ihex_pkg::KIND_ACK;
            r_fin_eof    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_app_start  <= ihex_pkg::APP_START_RESET;
            r_high_limit <= ihex_pkg::HIGH_LIMIT_RESET;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_first     <= n_first;
            r_cks       <= n_cks;
            r_len       <= n_len;
            r_addr_low  <= n_addr_low;
            r_type      <= n_type;
            r_addr_high <= n_addr_high;
            r_overflow  <= n_overflow;
            r_finished  <= n_finished;
            r_idx       <= n_idx;
            r_fin_kind  <= n_fin_kind;
            r_fin_eof   <= n_fin_eof;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ihex_pkg::CFG_APP_START:  r_app_start  <= i_cfg_data;
                    ihex_pkg::CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data[7:0];
                    default:                  r_app_start  <= r_app_start;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_rx.valid) begin
            r_char <= i_rx.rx_char;
        end
        if (buf_we) begin
            r_buf[buf_waddr] <= byte_val;
        end
        r_out_kind <= n_out_kind;
        r_out_addr <= n_out_addr;
        r_out_data <= n_out_data;
        r_out_eof  <= n_out_eof;
        r_out_last <= n_out_last;
    end

`ifndef SYNTH
    // a write result never closes a line
    a_write_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == ihex_pkg::KIND_WRITE |-> !r_out_last)
        else $error("write result marked last");

    // end of file holds until reset
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("end of file flag dropped");

    // character position saturates at the line limit
    a_pos_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= ihex_pkg::POS_W'(ihex_pkg::POS_CAP))
        else $error("character position past limit");

    // the write burst never runs past the data buffer
    a_burst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WRITE |-> r_idx <= ihex_pkg::CNT_W'(ihex_pkg::MAX_DATA_BYTES))
        else $error("write burst index past buffer");
`endif

endmodule

>>> sim/intel_hex_record_loader_tb.sv
module intel_hex_record_loader_tb;
    import ihex_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int MAX_GAP       = 5;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_CHARS   = 56;
    localparam int NUM_PHASES    = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int NUM_HEAD      = 17;
    localparam int NUM_HOLD      = 3;
    localparam int NUM_CLOSE     = 2;
    localparam int PAYLOAD_MAX   = 20;

    localparam logic [7:0] START_CODE = 8'h3A;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] CUT_ALL    = 8'd99;

    // one response as seen on o_res
    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
        logic              eof;
        logic              last;
    } loader_resp_t;

    // one hex line to build: header, first two data bytes, and ways to break it
    typedef struct packed {
        logic [7:0]  len;
        logic [15:0] addr;
        logic [7:0]  rtype;
        logic [7:0]  d0;
        logic [7:0]  d1;
        logic [7:0]  sum_err;   // added to the correct checksum byte
        logic [7:0]  cut;       // characters dropped before the line end
        logic [7:0]  tail;      // junk characters after the checksum
        bit          lower;     // lower case hex letters
        bit          typed;     // closing response typed in below
        logic [1:0]  exp_kind;
        bit          exp_eof;
    } hex_line_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [ADDR_W-1:0] cfg_data;

    ihex_char_if rx_if ();
    ihex_res_if  res_if ();

    intel_hex_record_loader uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_rx        (rx_if),
        .o_res       (res_if)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // directed lines
    // len, addr, type, d0, d1, sum_err, cut, tail, lower, typed, kind, eof
    // ---------------------------------------------------------------
    hex_line_t head_lines [NUM_HEAD] = '{
        // two writes right at the application start
        '{8'h02, 16'h0400, REC_DATA, 8'hA5, 8'h5A, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0, KIND_ACK, 1'b0},
        // one below the application start, ack only
        '{8'h01, 16'h03FF, REC_DATA, 8'hFF, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        // bad checksum
        '{8'h01, 16'h0400, REC_DATA, 8'h00, 8'h00, 8'h01, 8'd0, 8'd0, 1'b0, 1'b1, KIND_NAK, 1'b0},
        // short line, last checksum digit missing
        '{8'h01, 16'h0400, REC_DATA, 8'h11, 8'h22, 8'h00, 8'd1, 8'd0, 1'b0, 1'b1, KIND_NAK, 1'b0},
        // more data bytes than the buffer holds
        '{8'h11, 16'h0400, REC_DATA, 8'h33, 8'h44, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_NAK, 1'b0},
        // full buffer of writes at the top of the low address space
        '{8'h10, 16'hFFF0, REC_DATA, 8'h00, 8'hFF, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0, KIND_ACK, 1'b0},
        // extended address just below the high byte limit
        '{8'h02, 16'h0000, REC_EXTADDR, 8'h00, 8'h2F, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        '{8'h10, 16'hFFF8, REC_DATA, 8'hFF, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0, KIND_ACK, 1'b0},
        // extended address record too short to change the high byte
        '{8'h01, 16'h0000, REC_EXTADDR, 8'h55, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        // high byte at the limit, data is acked but not written
        '{8'h02, 16'h0000, REC_EXTADDR, 8'h00, 8'h30, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        '{8'h01, 16'hFFFF, REC_DATA, 8'h12, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        // unknown record type
        '{8'h04, 16'h1234, 8'hFF, 8'h9C, 8'h63, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        // overlong line, junk after the checksum byte
        '{8'h00, 16'h0400, REC_DATA, 8'h00, 8'h00, 8'h00, 8'd0, 8'd40, 1'b0, 1'b1, KIND_ACK, 1'b0},
        // back to high byte zero
        '{8'h02, 16'h0000, REC_EXTADDR, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        // bare line end
        '{8'h00, 16'h0000, REC_DATA, 8'h00, 8'h00, 8'h00, CUT_ALL, 8'd0, 1'b0, 1'b1, KIND_NAK, 1'b0},
        // end of file record with a bad checksum does not finish
        '{8'h00, 16'h0000, REC_EOF, 8'h00, 8'h00, 8'h01, 8'd0, 8'd0, 1'b0, 1'b1, KIND_NAK, 1'b0},
        // lower case letters decode to other values
        '{8'h03, 16'h0A0B, REC_DATA, 8'hAB, 8'hCD, 8'h00, 8'd0, 8'd0, 1'b1, 1'b0, KIND_ACK, 1'b0}
    };

    // lines sent while the receiver holds off, enough writes to back up the block
    hex_line_t hold_lines [NUM_HOLD] = '{
        '{8'h02, 16'h0000, REC_EXTADDR, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b0},
        '{8'h10, 16'h2000, REC_DATA, 8'h01, 8'h02, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0, KIND_ACK, 1'b0},
        '{8'h10, 16'h3000, REC_DATA, 8'hFE, 8'hFD, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0, KIND_ACK, 1'b0}
    };

    // end of file, then a line that must be ignored
    hex_line_t close_lines [NUM_CLOSE] = '{
        '{8'h00, 16'h0000, REC_EOF, 8'h00, 8'h00, 8'h00, 8'd0, 8'd0, 1'b0, 1'b1, KIND_ACK, 1'b1},
        '{8'h02, 16'h0400, REC_DATA, 8'h77, 8'h88, 8'h00, 8'd0, 8'd0, 1'b0, 1'b0, KIND_ACK, 1'b0}
    };

    // register settings per random phase, the last one is drawn at random
    logic [ADDR_W-1:0] phase_start [NUM_PHASES] = '{24'h000400, 24'h000000, 24'hFFFFFF,
                                                    24'h000000, 24'h000000};
    logic [7:0]        phase_limit [NUM_PHASES] = '{8'd48, 8'hFF, 8'hFF, 8'h00, 8'h00};

    // ---------------------------------------------------------------
    // loader predictor state
    // ---------------------------------------------------------------
    logic [ADDR_W-1:0] cfg_app_start;
    logic [7:0]        cfg_high_limit;
    int                ln_pos;
    logic [7:0]        ln_nib;
    logic [7:0]        ln_sum;
    logic [7:0]        ln_len;
    logic [15:0]       ln_addr;
    logic [7:0]        ln_type;
    logic [7:0]        ln_buf [MAX_DATA_BYTES];
    bit                ln_overflow;
    logic [7:0]        ext_high;
    bit                stream_done;

    loader_resp_t step_responses [$];   // responses caused by the latest request
    loader_resp_t pending_responses [$];
    logic [7:0]   line_chars [$];

    int  errors;
    int  chars_sent;
    int  cycle_count;
    bit  src_idle;
    bit  sink_idle;
    bit  long_hold_req;

    function automatic loader_resp_t make_resp(input logic [1:0] kind,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [7:0] data,
                                               input logic eof, input logic last);
        loader_resp_t r;
        r = '{kind, addr, data, eof, last};
        return r;
    endfunction

    // ascii digit to its value, letters from 'A' up count as 10 and above
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        return (c >= CHAR_A) ? (c - CHAR_A + 8'd10) : (c - CHAR_ZERO);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return CHAR_ZERO + 8'(n);
        return (lower ? LOWER_A : CHAR_A) + 8'(n) - 8'd10;
    endfunction

    task automatic clear_line();
        ln_pos      = 0;
        ln_nib      = '0;
        ln_sum      = '0;
        ln_len      = '0;
        ln_addr     = '0;
        ln_type     = '0;
        ln_overflow = 1'b0;
    endtask

    task automatic reset_loader_model();
        cfg_app_start  = APP_START_RESET;
        cfg_high_limit = HIGH_LIMIT_RESET;
        clear_line();
        ext_high    = '0;
        stream_done = 1'b0;
        foreach (ln_buf[i]) ln_buf[i] = '0;
    endtask

    // byte idx of the line: header, then data, then checksum
    task automatic store_byte(input int idx, input logic [7:0] v);
        int d;
        if (idx == 0) begin
            ln_len = v;
        end else if (idx == 1) begin
            ln_addr[15:8] = v;
        end else if (idx == 2) begin
            ln_addr[7:0] = v;
        end else if (idx == 3) begin
            ln_type = v;
        end else begin
            d = idx - 4;
            if (d < ln_len) begin
                if (d < MAX_DATA_BYTES) ln_buf[d] = v;
                else ln_overflow = 1'b1;
            end else if (d > ln_len) begin
                // past the checksum byte
                return;
            end
        end
        ln_sum = ln_sum + v;
    endtask

    task automatic close_line();
        logic [ADDR_W-1:0] base;
        base = {ext_high, ln_addr};
        if (ln_pos < 2 * int'(ln_len) + 11 || ln_overflow || ln_sum != 8'h00) begin
            step_responses.push_back(make_resp(KIND_NAK, '0, '0, 1'b0, 1'b1));
        end else if (ln_type == REC_DATA) begin
            if (ext_high < cfg_high_limit && base >= cfg_app_start) begin
                for (int i = 0; i < ln_len && i < MAX_DATA_BYTES; i++) begin
                    step_responses.push_back(make_resp(KIND_WRITE, base + ADDR_W'(i),
                                                       ln_buf[i], 1'b0, 1'b0));
                end
            end
            step_responses.push_back(make_resp(KIND_ACK, '0, '0, 1'b0, 1'b1));
        end else if (ln_type == REC_EOF) begin
            stream_done = 1'b1;
            step_responses.push_back(make_resp(KIND_ACK, '0, '0, 1'b1, 1'b1));
        end else begin
            if (ln_type == REC_EXTADDR && ln_len >= 8'd2) ext_high = ln_buf[1];
            step_responses.push_back(make_resp(KIND_ACK, '0, '0, 1'b0, 1'b1));
        end
        clear_line();
    endtask

    // advance the predictor by one accepted character
    task automatic decode_char(input logic [7:0] c);
        int p;
        logic [7:0] v;
        step_responses.delete();
        if (stream_done) return;
        if (c == LINE_END) begin
            close_line();
            return;
        end
        if (ln_pos >= POS_CAP) return;
        p = ln_pos;
        ln_pos = p + 1;
        if (p == 0) return;             // start code position
        if (p % 2 == 1) begin
            ln_nib = digit_value(c);
        end else begin
            v = {ln_nib[3:0], 4'h0} | digit_value(c);
            store_byte((p - 2) / 2, v);
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus side
    // ---------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_char <= c;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        chars_sent++;
    endtask

    // send line_chars, predicting each request as it is taken
    task automatic feed_line(input bit typed, input loader_resp_t typed_resp);
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
        foreach (line_chars[i]) begin
            send_char(line_chars[i]);
            decode_char(line_chars[i]);
            if (typed && i == line_chars.size() - 1) begin
                pending_responses.push_back(typed_resp);
            end else begin
                foreach (step_responses[k]) pending_responses.push_back(step_responses[k]);
            end
        end
    endtask

    task automatic send_line(input hex_line_t r);
        logic [7:0] payload [PAYLOAD_MAX];
        logic [7:0] fields [$];
        logic [7:0] sum;
        int n_data;
        foreach (payload[i]) payload[i] = 8'($urandom);
        payload[0] = r.d0;
        payload[1] = r.d1;
        n_data = (r.len > PAYLOAD_MAX) ? PAYLOAD_MAX : int'(r.len);
        fields.push_back(r.len);
        fields.push_back(r.addr[15:8]);
        fields.push_back(r.addr[7:0]);
        fields.push_back(r.rtype);
        for (int i = 0; i < n_data; i++) fields.push_back(payload[i]);
        sum = '0;
        foreach (fields[i]) sum = sum + fields[i];
        fields.push_back(r.sum_err - sum);

        line_chars.delete();
        line_chars.push_back(START_CODE);
        foreach (fields[i]) begin
            line_chars.push_back(hex_char(fields[i][7:4], r.lower));
            line_chars.push_back(hex_char(fields[i][3:0], r.lower));
        end
        if (r.cut >= line_chars.size()) line_chars.delete();
        else repeat (r.cut) void'(line_chars.pop_back());
        repeat (r.tail) line_chars.push_back(8'($urandom_range(8'h20, 8'h7E)));
        line_chars.push_back(LINE_END);
        feed_line(r.typed, make_resp(r.exp_kind, '0, '0, r.exp_eof, 1'b1));
    endtask

    // any byte values, stray line ends included
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 30);
        line_chars.delete();
        repeat (n) line_chars.push_back(8'($urandom_range(0, 255)));
        line_chars.push_back(LINE_END);
        feed_line(1'b0, '0);
    endtask

    // mostly well formed records with random content, some broken ones
    function automatic hex_line_t random_line();
        hex_line_t r;
        int pick;
        r = '0;
        pick = $urandom_range(0, 18);
        r.len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, MAX_DATA_BYTES))
                                            : 8'($urandom_range(0, 4));
        r.addr  = 16'($urandom);
        r.d0    = 8'($urandom);
        r.d1    = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8'h3F));
        r.rtype = REC_DATA;
        if (pick >= 10 && pick <= 12) begin
            r.rtype = REC_EXTADDR;
            if (pick != 12) r.len = 8'd2;
        end
        if (pick == 13) begin
            r.rtype = 8'($urandom);
            // a stray end of file must not end the run early
            if (r.rtype == REC_EOF) r.sum_err = 8'h01;
        end
        if (pick == 14) begin
            r.rtype   = REC_EOF;
            r.sum_err = 8'($urandom_range(1, 255));
        end
        if (pick == 15) r.sum_err = 8'($urandom_range(1, 255));
        if (pick == 16) r.cut = 8'($urandom_range(1, 12));
        if (pick == 17) r.len = 8'($urandom_range(MAX_DATA_BYTES + 1, 255));
        if (pick == 18) r.lower = 1'b1;
        if ($urandom_range(0, 9) == 0) r.tail = 8'($urandom_range(1, 20));
        return r;
    endfunction

    // both registers, back to back, only while the block is idle
    task automatic set_config(input logic [ADDR_W-1:0] app_start, input logic [7:0] limit);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_APP_START;
        cfg_data  <= app_start;
        @(posedge i_clk);
        cfg_index <= CFG_HIGH_LIMIT;
        cfg_data  <= {{(ADDR_W - 8){1'b0}}, limit};
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_app_start  = app_start;
        cfg_high_limit = limit;
    endtask

    // all responses in, then room for a line end still being worked on
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // response side
    // ---------------------------------------------------------------
    task automatic check_response();
        loader_resp_t want;
        if (pending_responses.size() == 0) begin
            $error("unexpected response: kind %0d address %h data %h",
                   res_if.kind, res_if.write_address, res_if.write_data);
            errors++;
            return;
        end
        want = pending_responses.pop_front();
        if (res_if.kind !== want.kind) begin
            $error("kind mismatch: expected %0d, got %0d", want.kind, res_if.kind);
            errors++;
        end
        if (res_if.write_address !== want.addr) begin
            $error("write_address mismatch: expected %h, got %h", want.addr,
                   res_if.write_address);
            errors++;
        end
        if (res_if.write_data !== want.data) begin
            $error("write_data mismatch: expected %h, got %h", want.data, res_if.write_data);
            errors++;
        end
        if (res_if.end_of_file !== want.eof) begin
            $error("end_of_file mismatch: expected %0b, got %0b", want.eof,
                   res_if.end_of_file);
            errors++;
        end
        if (res_if.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, res_if.last);
            errors++;
        end
    endtask

    // receiver: a random wait after each response, or one long hold when asked
    initial begin
        int hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                check_response();
                hold_left = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        int phase_base;
        errors        = 0;
        chars_sent    = 0;
        cycle_count   = 0;
        src_idle      = 1'b1;
        sink_idle     = 1'b1;
        long_hold_req = 1'b0;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_APP_START;
        cfg_data      <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_char <= '0;
        reset_loader_model();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed lines under the reset settings
        set_config(APP_START_RESET, HIGH_LIMIT_RESET);
        for (int i = 0; i < NUM_HEAD; i++) send_line(head_lines[i]);
        wait_drained();

        // random phases, each under its own register setting
        phase_start[NUM_PHASES - 1] = ADDR_W'($urandom_range(0, 24'h03FFFF));
        phase_limit[NUM_PHASES - 1] = 8'($urandom_range(1, 8'h40));
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(phase_start[p], phase_limit[p]);
            if (p == 1) begin
                // receiver stalls long while full-length write lines keep coming
                long_hold_req = 1'b1;
                for (int i = 0; i < NUM_HOLD; i++) send_line(hold_lines[i]);
            end
            phase_base = chars_sent;
            while (chars_sent - phase_base < PHASE_CHARS) begin
                if ($urandom_range(0, 19) == 0) send_noise();
                else send_line(random_line());
            end
            wait_drained();
        end

        // end of file, then everything after it is ignored
        for (int i = 0; i < NUM_CLOSE; i++) send_line(close_lines[i]);
        send_noise();
        wait_drained();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
